@@ rtl/cspa_pkg.sv @@
package cspa_pkg;

  localparam int MAX_DEPTH  = 256;
  localparam int NUM_GROUPS = 4096;

  localparam int LVL_W   = $clog2(MAX_DEPTH);
  localparam int GRP_W   = $clog2(NUM_GROUPS);
  localparam int DEPTH_W = 9;
  localparam int GID_W   = 12;
  localparam int DATA_W  = 64;
  localparam int STAMP_W = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_REDUCE_BY_MAX = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLLAPSE_ALLOC = 1'd1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RESULT,
    S_PUSH,
    S_COUNT,
    S_SELF,
    S_LVL_TBL,
    S_LVL_UPD
  } state_e;

endpackage

@@ rtl/call_stack_profile_aggregator_top.sv @@
// Channel  | Ports                                              | Handshake
// ---------+----------------------------------------------------+--------------------------
// in       | mode_i .. sample_amount_i                          | start high, busy low
// out      | self_total_o, self_count_o, cumulative_total_o     | done_o strobe, one cycle
// config   | cfg_we_i, cfg_idx_i, cfg_data_i                    | cfg_we_i high, no wait
//
// A read word passes through S_RESULT, a node word without a sample through S_PUSH, and
// one with a sample through S_PUSH, S_COUNT, S_SELF, then S_LVL_TBL and S_LVL_UPD per stack
// level walked; the shared 64-bit add/max unit and single group table port set that order.
// After reset the block clears its group tables, one entry a cycle, with busy high;
// configuration writes are taken meanwhile.
// The receiver cannot stall: a result is shown for exactly one cycle.
module call_stack_profile_aggregator_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                mode_i,
  input  logic [cspa_pkg::DEPTH_W-1:0]        frame_depth_i,
  input  logic [cspa_pkg::GID_W-1:0]          group_id_i,
  input  logic                                alloc_frame_i,
  input  logic                                profiler_frame_i,
  input  logic                                has_sample_i,
  input  logic signed [cspa_pkg::DATA_W-1:0]  sample_count_i,
  input  logic signed [cspa_pkg::DATA_W-1:0]  sample_amount_i,
  input  logic                                cfg_we_i,
  input  logic [cspa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [cspa_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                                done_o,
  output logic signed [cspa_pkg::DATA_W-1:0]  self_total_o,
  output logic signed [cspa_pkg::DATA_W-1:0]  self_count_o,
  output logic signed [cspa_pkg::DATA_W-1:0]  cumulative_total_o
);
  import cspa_pkg::*;

  state_e state_q, state_d;

  logic [GRP_W-1:0]   clr_q;
  logic               reduce_q;
  logic               collapse_q;
  logic [STAMP_W-1:0] serial_q;

  logic [LVL_W-1:0]   lvl_q, top_q, l_q;
  logic [GRP_W-1:0]   gid_q, grp_q;
  logic               fold_q, smp_q;
  logic [DATA_W-1:0]  cnt_q, amt_q;

  logic [GRP_W-1:0]   stack_mem [MAX_DEPTH];
  logic [GRP_W-1:0]   stk_rd_q;
  logic [DATA_W-1:0]  self_mem  [NUM_GROUPS];
  logic [DATA_W-1:0]  cnt_mem   [NUM_GROUPS];
  logic [DATA_W-1:0]  cum_mem   [NUM_GROUPS];
  logic [STAMP_W-1:0] stamp_mem [NUM_GROUPS];
  logic [DATA_W-1:0]  self_rd_q, cnt_rd_q, cum_rd_q;
  logic [STAMP_W-1:0] stamp_rd_q;

  logic               accept;
  logic               depth_ok;
  logic [LVL_W-1:0]   lvl_in;
  logic [GRP_W-1:0]   gid_in;
  logic [GRP_W-1:0]   tg;
  logic [LVL_W-1:0]   stk_raddr;
  logic [GRP_W-1:0]   tbl_raddr, tbl_waddr;
  logic               stk_we, self_we, cnt_we, cum_we, stamp_we;
  logic [DATA_W-1:0]  alu_a, alu_b, alu_res, tbl_wdata;
  logic               alu_max;
  logic               charge;

  assign accept   = start && (state_q == S_IDLE);
  assign depth_ok = (frame_depth_i != '0) && (32'(frame_depth_i) <= MAX_DEPTH);
  assign lvl_in   = LVL_W'(frame_depth_i - DEPTH_W'(1));
  assign gid_in   = group_id_i[GRP_W-1:0];
  assign tg       = fold_q ? stk_rd_q : gid_q;
  assign charge   = reduce_q || (stamp_rd_q != serial_q);

  // Shared unit: wrapping add, or signed maximum of the two operands.
  always_comb begin
    if (alu_max) begin
      alu_res = ($signed(alu_b) > $signed(alu_a)) ? alu_b : alu_a;
    end else begin
      alu_res = alu_a + alu_b;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == GRP_W'(NUM_GROUPS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (mode_i) state_d = S_RESULT;
          else if (depth_ok) state_d = S_PUSH;
        end
      end
      S_RESULT:  state_d = S_IDLE;
      S_PUSH:    state_d = smp_q ? S_COUNT : S_IDLE;
      S_COUNT:   state_d = S_SELF;
      S_SELF:    state_d = S_LVL_TBL;
      S_LVL_TBL: state_d = S_LVL_UPD;
      S_LVL_UPD: state_d = (l_q == top_q) ? S_IDLE : S_LVL_TBL;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    stk_raddr = l_q;
    tbl_raddr = grp_q;
    tbl_waddr = grp_q;
    tbl_wdata = alu_res;
    stk_we    = 1'b0;
    self_we   = 1'b0;
    cnt_we    = 1'b0;
    cum_we    = 1'b0;
    stamp_we  = 1'b0;
    alu_a     = cum_rd_q;
    alu_b     = amt_q;
    alu_max   = reduce_q;
    unique case (state_q)
      S_CLEAR: begin
        tbl_waddr = clr_q;
        tbl_wdata = '0;
        self_we   = 1'b1;
        cnt_we    = 1'b1;
        cum_we    = 1'b1;
        stamp_we  = 1'b1;
      end
      S_IDLE: begin
        // Parent slot and the group entry are fetched as the word is taken.
        stk_raddr = LVL_W'(frame_depth_i - DEPTH_W'(2));
        tbl_raddr = gid_in;
      end
      S_PUSH: begin
        stk_we    = 1'b1;
        tbl_raddr = tg;
      end
      S_COUNT: begin
        alu_a   = cnt_rd_q;
        alu_b   = cnt_q;
        alu_max = 1'b0;
        cnt_we  = 1'b1;
      end
      S_SELF: begin
        alu_a     = self_rd_q;
        self_we   = 1'b1;
        stk_raddr = '0;
      end
      S_LVL_TBL: begin
        tbl_raddr = stk_rd_q;
      end
      S_LVL_UPD: begin
        cum_we    = charge;
        stamp_we  = charge && !reduce_q;
        stk_raddr = l_q + LVL_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stack_mem[lvl_q] <= tg;
    stk_rd_q <= stack_mem[stk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (self_we) self_mem[tbl_waddr] <= tbl_wdata;
    if (cnt_we) cnt_mem[tbl_waddr] <= tbl_wdata;
    if (cum_we) cum_mem[tbl_waddr] <= tbl_wdata;
    if (stamp_we) stamp_mem[tbl_waddr] <= (state_q == S_CLEAR) ? '0 : serial_q;
    self_rd_q  <= self_mem[tbl_raddr];
    cnt_rd_q   <= cnt_mem[tbl_raddr];
    cum_rd_q   <= cum_mem[tbl_raddr];
    stamp_rd_q <= stamp_mem[tbl_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      reduce_q   <= 1'b0;
      collapse_q <= 1'b0;
      serial_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + GRP_W'(1);
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_REDUCE_BY_MAX:  reduce_q   <= cfg_data_i[0];
          REG_COLLAPSE_ALLOC: collapse_q <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      if (state_q == S_SELF && !reduce_q) serial_q <= serial_q + STAMP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lvl_q  <= lvl_in;
      gid_q  <= gid_in;
      // A root frame never folds.
      fold_q <= (profiler_frame_i || (alloc_frame_i && collapse_q)) && (lvl_in != '0);
      smp_q  <= has_sample_i;
      cnt_q  <= sample_count_i;
      amt_q  <= sample_amount_i;
    end
    unique case (state_q)
      S_PUSH: begin
        grp_q <= tg;
        top_q <= fold_q ? lvl_q - LVL_W'(1) : lvl_q;
      end
      S_SELF:    l_q   <= '0;
      S_LVL_TBL: grp_q <= stk_rd_q;
      S_LVL_UPD: l_q   <= l_q + LVL_W'(1);
      default: begin
      end
    endcase
  end

  assign busy               = (state_q != S_IDLE);
  assign done_o             = (state_q == S_RESULT);
  assign self_total_o       = self_rd_q;
  assign self_count_o       = cnt_rd_q;
  assign cumulative_total_o = cum_rd_q;

endmodule

@@ tb/sv/profile_totals_pkg.sv @@
`timescale 1ns / 100ps

package profile_totals_pkg;
  import cspa_pkg::*;

  localparam logic MODE_NODE = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic signed [DATA_W-1:0] self_total;
    logic signed [DATA_W-1:0] self_count;
    logic signed [DATA_W-1:0] cumulative_total;
  } group_totals_t;

  class group_totals_model;
    bit [GID_W-1:0]          level_group [MAX_DEPTH];
    bit signed [DATA_W-1:0]  self_sum    [NUM_GROUPS];
    bit signed [DATA_W-1:0]  count_sum   [NUM_GROUPS];
    bit signed [DATA_W-1:0]  cum_sum     [NUM_GROUPS];
    bit [STAMP_W-1:0]        charge_stamp [NUM_GROUPS];
    bit [STAMP_W-1:0]        sample_serial;
    bit                      max_mode;
    bit                      fold_alloc;
    group_totals_t           pending_totals [$];
    int                      mismatches;
    int                      totals_checked;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_REDUCE_BY_MAX:  max_mode = val[0];
        REG_COLLAPSE_ALLOC: fold_alloc = val[0];
        default: ;
      endcase
    endfunction

    function void note_word(logic md, logic [DEPTH_W-1:0] depth, logic [GID_W-1:0] gid,
                            logic alloc, logic prof, logic has,
                            logic signed [DATA_W-1:0] cnt, logic signed [DATA_W-1:0] amt);
      int unsigned     lvl;
      int unsigned     top;
      bit [GID_W-1:0]  tg;
      bit              folds;
      bit [GID_W-1:0]  g;
      group_totals_t   t;
      if (md == MODE_READ) begin
        t.self_total       = self_sum[gid];
        t.self_count       = count_sum[gid];
        t.cumulative_total = cum_sum[gid];
        pending_totals.push_back(t);
        return;
      end
      if (depth == 0 || depth > MAX_DEPTH) return;
      lvl   = depth - 1;
      folds = prof || (alloc && fold_alloc);
      tg    = gid;
      top   = lvl;
      // A folded frame takes over its caller's slot, so its subtree is charged there.
      if (folds && lvl > 0) begin
        tg  = level_group[lvl-1];
        top = lvl - 1;
      end
      level_group[lvl] = tg;
      if (!has) return;
      count_sum[tg] += cnt;
      if (max_mode) begin
        if (amt > self_sum[tg]) self_sum[tg] = amt;
        for (int l = 0; l <= top; l++) begin
          g = level_group[l];
          if (amt > cum_sum[g]) cum_sum[g] = amt;
        end
      end else begin
        self_sum[tg] += amt;
        sample_serial++;
        // Each group is charged once per node, however often it sits on the stack.
        for (int l = 0; l <= top; l++) begin
          g = level_group[l];
          if (charge_stamp[g] != sample_serial) begin
            charge_stamp[g] = sample_serial;
            cum_sum[g] += amt;
          end
        end
      end
    endfunction

    task report_mismatch(string what, logic signed [DATA_W-1:0] got,
                         logic signed [DATA_W-1:0] want);
      mismatches++;
      $display("tb: mismatch on %s at %0t: got %0d, want %0d", what, $realtime, got, want);
    endtask

    task check_totals(logic signed [DATA_W-1:0] st, logic signed [DATA_W-1:0] sc,
                      logic signed [DATA_W-1:0] ct);
      group_totals_t want;
      if (pending_totals.size() == 0) begin
        report_mismatch("unexpected word", st, 0);
        return;
      end
      want = pending_totals.pop_front();
      totals_checked++;
      if (st !== want.self_total) report_mismatch("self_total", st, want.self_total);
      if (sc !== want.self_count) report_mismatch("self_count", sc, want.self_count);
      if (ct !== want.cumulative_total)
        report_mismatch("cumulative_total", ct, want.cumulative_total);
    endtask
  endclass

endpackage

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import cspa_pkg::*;
  import profile_totals_pkg::*;

  localparam bit [DATA_W-1:0] S64_MIN = 64'h8000_0000_0000_0000;
  localparam bit [DATA_W-1:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int DRAIN_CYCLES = 4 + 2 * MAX_DEPTH + 16;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  mode_i = MODE_NODE;
  logic [DEPTH_W-1:0]    frame_depth_i = '0;
  logic [GID_W-1:0]      group_id_i = '0;
  logic                  alloc_frame_i = 1'b0;
  logic                  profiler_frame_i = 1'b0;
  logic                  has_sample_i = 1'b0;
  logic signed [DATA_W-1:0] sample_count_i = '0;
  logic signed [DATA_W-1:0] sample_amount_i = '0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  done_o;
  logic signed [DATA_W-1:0] self_total_o;
  logic signed [DATA_W-1:0] self_count_o;
  logic signed [DATA_W-1:0] cumulative_total_o;

  group_totals_model sb = new();

  // Stimulus side view of which stack slots hold a group, so no node reads an empty slot.
  bit slot_written [MAX_DEPTH];
  int filled_levels;
  int cur_depth;
  bit cfg_fold;
  int words_sent;
  bit [GID_W-1:0] group_pool [8] = '{0, 1, 2, 5, 100, 2047, 2048, 4095};

  call_stack_profile_aggregator_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .mode_i(mode_i), .frame_depth_i(frame_depth_i), .group_id_i(group_id_i),
    .alloc_frame_i(alloc_frame_i), .profiler_frame_i(profiler_frame_i),
    .has_sample_i(has_sample_i), .sample_count_i(sample_count_i),
    .sample_amount_i(sample_amount_i), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .done_o(done_o), .self_total_o(self_total_o),
    .self_count_o(self_count_o), .cumulative_total_o(cumulative_total_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_totals(self_total_o, self_count_o, cumulative_total_o);
      if (cfg_we_i) sb.write_reg(cfg_idx_i, cfg_data_i);
      if (start && !busy)
        sb.note_word(mode_i, frame_depth_i, group_id_i, alloc_frame_i, profiler_frame_i,
                     has_sample_i, sample_count_i, sample_amount_i);
    end
  end

  function automatic bit [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return S64_MIN;
      1: return S64_MAX;
      2: return '1;
      3: return '0;
      4, 5, 6: return DATA_W'(signed'($urandom_range(0, 2000)) - 1000);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic bit [GID_W-1:0] pick_group();
    if ($urandom_range(0, 99) < 80) return group_pool[$urandom_range(0, 7)];
    return GID_W'($urandom_range(0, NUM_GROUPS - 1));
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(logic md, int depth, bit [GID_W-1:0] gid, bit alloc, bit prof,
                           bit has, bit [DATA_W-1:0] cnt, bit [DATA_W-1:0] amt);
    mode_i           <= md;
    frame_depth_i    <= DEPTH_W'(depth);
    group_id_i       <= gid;
    alloc_frame_i    <= alloc;
    profiler_frame_i <= prof;
    has_sample_i     <= has;
    sample_count_i   <= cnt;
    sample_amount_i  <= amt;
    start            <= 1'b1;
    do @(posedge clk_i); while (busy);
    words_sent++;
    if (md == MODE_NODE && depth >= 1 && depth <= MAX_DEPTH) begin
      slot_written[depth-1] = 1'b1;
      while (filled_levels < MAX_DEPTH && slot_written[filled_levels]) filled_levels++;
    end
    @(negedge clk_i);
  endtask

  task automatic node(int depth, bit [GID_W-1:0] gid, bit alloc, bit prof, bit has,
                      bit [DATA_W-1:0] cnt, bit [DATA_W-1:0] amt);
    send_word(MODE_NODE, depth, gid, alloc, prof, has, cnt, amt);
  endtask

  task automatic read_group(bit [GID_W-1:0] gid);
    send_word(MODE_READ, $urandom_range(0, 511), gid, 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_value(),
              pick_value());
  endtask

  task automatic sender_gap();
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (r < 50) gap = 0;
    else if (r < 85) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 20);
    else gap = $urandom_range(30, 80);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic wait_drain();
    int n;
    n = 0;
    while (sb.pending_totals.size() != 0 && n < 8 * DRAIN_CYCLES) begin
      @(negedge clk_i);
      n++;
    end
    if (sb.pending_totals.size() != 0) begin
      sb.report_mismatch("missing words", 0, sb.pending_totals.size());
      sb.pending_totals.delete();
    end
    // A node word gives no result, so let the last one finish before anything else.
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic close_phase();
    read_group(group_pool[$urandom_range(0, 7)]);
    start <= 1'b0;
    wait_drain();
  endtask

  task automatic set_regs(bit max_mode, bit fold);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_REDUCE_BY_MAX;
    cfg_data_i <= max_mode;
    @(negedge clk_i);
    cfg_idx_i  <= REG_COLLAPSE_ALLOC;
    cfg_data_i <= fold;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_fold    = fold;
  endtask

  // Pre-order walk: the next depth is at most one below the current node.
  task automatic random_node(int cap);
    int d;
    bit alloc;
    bit prof;
    bit has;
    if ($urandom_range(0, 99) < 55) d = cur_depth + 1;
    else d = $urandom_range(1, cur_depth + 1);
    if (d > cap) d = $urandom_range(1, cap);
    alloc = ($urandom_range(0, 3) == 0);
    prof  = ($urandom_range(0, 7) == 0);
    has   = ($urandom_range(0, 3) != 0);
    if ((has || prof || (alloc && cfg_fold)) && d - 1 > filled_levels) begin
      has  = 1'b0;
      prof = 1'b0;
      if (cfg_fold) alloc = 1'b0;
    end
    node(d, pick_group(), alloc, prof, has, pick_value(), pick_value());
    cur_depth = d;
  endtask

  task automatic run_random(int count, int cap);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 15) read_group(pick_group());
      else if (r < 20)
        node(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(MAX_DEPTH + 1, 511),
             GID_W'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
             1'($urandom_range(0, 1)), pick_value(), pick_value());
      else random_node(cap);
      sender_gap();
    end
  endtask

  task automatic deep_chain();
    for (int d = 1; d <= MAX_DEPTH; d++) begin
      node(d, pick_group(), $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0,
           (d % 64 == 0) || ($urandom_range(0, 15) == 0), pick_value(), pick_value());
      if (d % 32 == 0) read_group(pick_group());
      sender_gap();
    end
    cur_depth = MAX_DEPTH;
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // The block is still clearing its tables here; register writes are taken anyway.
    set_regs(1'b0, 1'b0);

    node(1, 0, 0, 0, 1, 1, 5);
    node(2, 4095, 1, 0, 1, S64_MAX, S64_MAX);
    node(3, 7, 0, 1, 1, 2, S64_MIN);
    node(3, 9, 0, 0, 0, 0, 0);
    node(4, 9, 0, 0, 1, S64_MIN, '1);
    node(1, 3, 0, 1, 1, 1, 100);
    node(0, 11, 0, 0, 1, 1, 1);
    node(MAX_DEPTH + 1, 11, 0, 0, 1, 1, 1);
    node(511, 4095, 1, 1, 1, '1, '1);
    node(2, 3, 0, 0, 1, 1, 7);
    read_group(0);
    read_group(4095);
    read_group(7);
    read_group(9);
    read_group(3);
    read_group(100);
    close_phase();

    set_regs(1'b0, 1'b1);
    node(2, 20, 1, 0, 1, 1, 50);
    node(3, 21, 1, 1, 0, 0, 0);
    node(4, 22, 0, 0, 1, 1, 1);
    read_group(3);
    read_group(20);
    read_group(22);
    close_phase();

    set_regs(1'b1, 1'b0);
    node(1, 0, 0, 0, 1, 1, -5);
    node(2, 5, 0, 0, 1, 1, 1000);
    node(2, 5, 0, 0, 1, 1, 10);
    read_group(0);
    read_group(5);
    close_phase();

    run_random(130, 24);
    close_phase();
    set_regs(1'b1, 1'b1);
    run_random(130, 24);
    close_phase();
    set_regs(1'b0, 1'b1);
    deep_chain();
    run_random(100, 24);
    close_phase();
    set_regs(1'b0, 1'b0);
    run_random(130, 32);
    close_phase();
    set_regs(1'b1, 1'b1);
    run_random(60, MAX_DEPTH);
    close_phase();

    $display("tb: %0d words driven, %0d group totals checked", words_sent, sb.totals_checked);
    $display("tb: covered sum and max reduction, allocator folding off and on, full depth");
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(40_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/cspa_pkg.sv
rtl/call_stack_profile_aggregator_top.sv
tb/sv/profile_totals_pkg.sv
tb/sv/testbench.sv
